### rtl/core/drum_voice_synth_assert.svh
// ---------------------------------------------------------------------------
// Drum voice assertion macros
// Short forms for the concurrent checks of the drum voice, clocked on clk and
// disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DRUM_VOICE_SYNTH_ASSERT_SVH
`define DRUM_VOICE_SYNTH_ASSERT_SVH

// Same-cycle implication.
`define DVS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drum voice check failed");

// Next-cycle implication.
`define DVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drum voice check failed");

`endif

### rtl/core/dvs_pkg.sv
// ---------------------------------------------------------------------------
// Drum voice package
// Types, codes, per-kind tables and the quarter-wave sine polynomial.
// ---------------------------------------------------------------------------
package dvs_pkg;

  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_TRIGGER = 1'b1;

  localparam logic [3:0] KIND_KICK    = 4'd0;
  localparam logic [3:0] KIND_SNARE   = 4'd1;
  localparam logic [3:0] KIND_HAT     = 4'd2;
  localparam logic [3:0] KIND_TOM_LO  = 4'd3;
  localparam logic [3:0] KIND_TOM_MID = 4'd4;
  localparam logic [3:0] KIND_TOM_HI  = 4'd5;
  localparam logic [3:0] KIND_CLAP    = 4'd6;
  localparam logic [3:0] KIND_RIM     = 4'd7;
  localparam logic [3:0] KIND_COWBELL = 4'd8;
  localparam logic [3:0] KIND_CLAVE   = 4'd9;
  localparam logic [3:0] KIND_PERC    = 4'd10;

  localparam logic [19:0] SAMPLE_PERIOD_RESET = 20'd89478;
  localparam logic [23:0] ENV_ONE             = 24'h800000;
  localparam logic [32:0] MS_SCALE            = 33'd1000;
  localparam logic [31:0] LCG_MULT_LO         = 32'hDEECE66D;
  localparam logic [15:0] LCG_MULT_HI         = 16'd5;
  localparam logic [47:0] LCG_ADD             = 48'd11;
  localparam logic [24:0] RIM_MULT            = 25'd20132659;
  localparam logic [24:0] BELL_MULT           = 25'd12582912;
  localparam int          DIV_BITS            = 21;
  localparam logic [4:0]  DIV_LAST            = 5'd20;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRG_FREQ,
    ST_TRG_SCALE,
    ST_TRG_DIVLOAD,
    ST_TRG_DIV,
    ST_TERM,
    ST_SCALE,
    ST_WAVE_SIN,
    ST_NOISE_LO,
    ST_NOISE_HI,
    ST_ACC,
    ST_GAIN,
    ST_MIX,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_SIN_RAW,
    SRC_SIN_KICK,
    SRC_SIN_TOM,
    SRC_SIN_RIM,
    SRC_SIN_BELL,
    SRC_NOISE
  } src_t;

  typedef struct packed {
    src_t        src;
    logic [15:0] coef;
  } term_t;

  function automatic logic [11:0] kind_freq(input logic [3:0] kind);
    logic [11:0] f;
    unique case (kind)
      KIND_KICK:    f = 12'd60;
      KIND_SNARE:   f = 12'd400;
      KIND_TOM_LO:  f = 12'd80;
      KIND_TOM_MID: f = 12'd120;
      KIND_TOM_HI:  f = 12'd180;
      KIND_RIM:     f = 12'd800;
      KIND_COWBELL: f = 12'd540;
      KIND_CLAVE:   f = 12'd2500;
      default:      f = 12'd0;
    endcase
    return f;
  endfunction

  function automatic logic [8:0] kind_amp_ms(input logic [3:0] kind);
    logic [8:0] t;
    unique case (kind)
      KIND_KICK:    t = 9'd300;
      KIND_SNARE:   t = 9'd200;
      KIND_HAT:     t = 9'd50;
      KIND_TOM_LO:  t = 9'd400;
      KIND_TOM_MID: t = 9'd350;
      KIND_TOM_HI:  t = 9'd300;
      KIND_CLAP:    t = 9'd150;
      KIND_RIM:     t = 9'd30;
      KIND_COWBELL: t = 9'd200;
      KIND_CLAVE:   t = 9'd20;
      default:      t = 9'd100;
    endcase
    return t;
  endfunction

  function automatic logic [8:0] kind_pitch_ms(input logic [3:0] kind);
    logic [8:0] t;
    unique case (kind)
      KIND_KICK:    t = 9'd50;
      KIND_TOM_LO:  t = 9'd80;
      KIND_TOM_MID: t = 9'd70;
      KIND_TOM_HI:  t = 9'd60;
      default:      t = 9'd0;
    endcase
    return t;
  endfunction

  // Mix recipe: up to three weighted sources per kind, then SRC_NONE.
  function automatic term_t term_of(input logic [3:0] kind, input logic [1:0] idx);
    term_t t;
    t = '{src: SRC_NONE, coef: 16'd0};
    unique case (kind)
      KIND_KICK: begin
        if (idx == 2'd0) t = '{src: SRC_SIN_KICK, coef: 16'd32768};
      end
      KIND_SNARE: begin
        if (idx == 2'd0) t = '{src: SRC_NOISE, coef: 16'd22938};
        if (idx == 2'd1) t = '{src: SRC_SIN_RAW, coef: 16'd6881};
      end
      KIND_TOM_LO, KIND_TOM_MID, KIND_TOM_HI: begin
        if (idx == 2'd0) t = '{src: SRC_SIN_TOM, coef: 16'd26214};
        if (idx == 2'd1) t = '{src: SRC_NOISE, coef: 16'd3277};
      end
      KIND_CLAP: begin
        if (idx == 2'd0) t = '{src: SRC_NOISE, coef: 16'd19661};
      end
      KIND_RIM: begin
        if (idx == 2'd0) t = '{src: SRC_SIN_RAW, coef: 16'd16384};
        if (idx == 2'd1) t = '{src: SRC_SIN_RIM, coef: 16'd9830};
        if (idx == 2'd2) t = '{src: SRC_NOISE, coef: 16'd6554};
      end
      KIND_COWBELL: begin
        if (idx == 2'd0) t = '{src: SRC_SIN_RAW, coef: 16'd9175};
        if (idx == 2'd1) t = '{src: SRC_SIN_BELL, coef: 16'd6881};
      end
      KIND_CLAVE: begin
        if (idx == 2'd0) t = '{src: SRC_SIN_RAW, coef: 16'd19661};
      end
      default: begin
        if (idx == 2'd0) t = '{src: SRC_NOISE, coef: 16'd16384};
      end
    endcase
    return t;
  endfunction

  // Quarter-wave odd polynomial in Q30; r runs over 0..16384 for 0..pi/2.
  // Arithmetic right shifts of signed values give the floor shifts.
  function automatic logic signed [15:0] quarter_sine(input logic [14:0] r);
    logic signed [63:0] z;
    logic signed [63:0] z2;
    logic signed [63:0] a;
    logic signed [63:0] y;
    z  = {33'd0, r, 16'd0};
    z2 = (z * z) >>> 30;
    a  = 64'sd172270;
    a  = ((a * z2) >>> 30) - 64'sd5026995;
    a  = ((a * z2) >>> 30) + 64'sd85569305;
    a  = ((a * z2) >>> 30) - 64'sd693598668;
    a  = ((a * z2) >>> 30) + 64'sd1686629713;
    y  = (((a * z) >>> 30) + 64'sd16384) >>> 15;
    if (y > 64'sd32767) y = 64'sd32767;
    return y[15:0];
  endfunction

endpackage

### rtl/core/dvs_ifs.sv
// ---------------------------------------------------------------------------
// Drum voice channel interfaces
// Valid/ready channels for the command beats and the sample beats.
// ---------------------------------------------------------------------------
interface dvs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] velocity;
  logic [3:0]  drum_kind;

  modport source (output valid, output mode, output velocity, output drum_kind,
                  input ready);
  modport sink (input valid, input mode, input velocity, input drum_kind,
                output ready);
endinterface

interface dvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               voice_active;

  modport source (output valid, output sample, output voice_active, input ready);
  modport sink (input valid, input sample, input voice_active, output ready);
endinterface

### rtl/core/drum_voice_synth.sv
// ---------------------------------------------------------------------------
// Drum voice synthesizer
// One drum voice with eleven kinds, one output sample per tick command,
// built around a single shared multiplier under a small sequencer.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents
//  --------  ---  ---------------------------------------------------------
//  in_ch     in   mode (0 tick, 1 trigger), velocity Q1.15, drum_kind
//  out_ch    out  sample Q1.15 saturated, voice_active
//  cfg_wr_*  in   sample_period (2^32 / sample rate), write only
//
//  A sounding tick runs from acceptance to the registered sample through the
//  shared 33x33 multiplier, one multiply at a time (three multiplies per
//  noise term, one per sine term plus one for a pitch-scaled phase, then
//  gain and mix). A silent tick goes straight to the final state. A trigger
//  computes its phase step, then its decay steps from a one-bit-per-cycle
//  restoring divider, run once, or twice for kick and toms.
//  Reset is synchronous; it clears the voice and reloads the default period.
//  in_ch is ready only while the sequencer is idle; a finished sample sits
//  in the output register while the next beat is taken, and a stalled
//  out_ch holds the sequencer in its final state until that register frees.
//
`include "drum_voice_synth_assert.svh"

module drum_voice_synth #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_INT_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [19:0] cfg_wr_data,
  dvs_in_if.sink      in_ch,
  dvs_out_if.source   out_ch
);

  // Phase is PHASE_INT_BITS.FRAC_BITS turns; the table covers one turn and
  // its depth must be a power of two.
  localparam int FRAC_BITS = 32 - PHASE_INT_BITS;
  localparam int ROM_AW    = $clog2(SINE_TABLE_DEPTH);
  localparam int P_STEP    = 65536 / SINE_TABLE_DEPTH;
  localparam int RND_W     = 32 + PHASE_INT_BITS;
  localparam int SCALE_TOP = 23 + FRAC_BITS - 1;

  typedef logic signed [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  // Full-wave table folded from the quarter-wave polynomial.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [15:0]        p;
    logic [14:0]        r;
    logic signed [15:0] v;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      p = 16'(k * P_STEP);
      r = {1'b0, p[13:0]};
      if (p[14]) r = 15'd16384 - r;
      v = dvs_pkg::quarter_sine(r);
      rom[k] = p[15] ? -v : v;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Voice state.
  logic [19:0] sample_period;
  logic        sounding;
  logic [3:0]  kind_held;
  logic [15:0] hit_level;
  logic [31:0] phase_turns;
  logic [31:0] phase_step;
  logic [23:0] amp_env;
  logic [23:0] amp_step;
  logic [23:0] pitch_env;
  logic [23:0] pitch_step;
  logic [47:0] noise_seed;

  // Sequencer and datapath registers.
  dvs_pkg::state_t    state, state_next;
  logic [1:0]         term_idx;
  logic signed [32:0] acc;
  logic signed [65:0] prod;
  logic signed [15:0] sine_q;
  logic [47:0]        seed_plo;
  logic [29:0]        spk;
  logic [20:0]        dvd;
  logic [8:0]         rem;
  logic [4:0]         div_cnt;
  logic               div_pitch;
  logic [15:0]        mix_sample;
  logic               mix_active;
  logic               out_valid;
  logic [15:0]        out_sample;
  logic               out_active;

  // Combinational helpers.
  logic signed [32:0] mul_a, mul_b;
  logic [ROM_AW-1:0]  rom_addr;
  logic               in_fire;
  logic               kind_ok;
  logic               pitched_held;
  dvs_pkg::term_t     term;
  logic [24:0]        scale_mult;
  logic [8:0]         div_den;
  logic [9:0]         rem_sh;
  logic               div_ge;
  logic [8:0]         rem_sub;
  logic [20:0]        quot;
  logic [30:0]        num_amp, num_pitch;
  logic [15:0]        lo_x5;
  logic [15:0]        seed_hi;
  logic [47:0]        seed_new;
  logic [15:0]        noise_wave;
  logic [17:0]        gain;
  logic signed [35:0] mix_wide;
  logic [15:0]        mix_sat;
  logic [RND_W-1:0]   step_rnd;
  logic [24:0]        amp_diff, pitch_diff;

  assign in_ch.ready         = (state == dvs_pkg::ST_IDLE);
  assign in_fire             = in_ch.valid && in_ch.ready;
  assign kind_ok             = (in_ch.drum_kind <= dvs_pkg::KIND_PERC);
  assign pitched_held        = (dvs_pkg::kind_pitch_ms(kind_held) != 9'd0);
  assign term                = dvs_pkg::term_of(kind_held, term_idx);
  assign out_ch.valid        = out_valid;
  assign out_ch.sample       = out_sample;
  assign out_ch.voice_active = out_active;

  // Phase multiplier for the pitch-bent and overtone sine sources.
  always_comb begin
    unique case (term.src)
      dvs_pkg::SRC_SIN_KICK: scale_mult = {1'b0, dvs_pkg::ENV_ONE}
                                          + {pitch_env, 1'b0};
      dvs_pkg::SRC_SIN_TOM:  scale_mult = {1'b0, dvs_pkg::ENV_ONE} + {1'b0, pitch_env}
                                          + {2'b0, pitch_env[23:1]};
      dvs_pkg::SRC_SIN_RIM:  scale_mult = dvs_pkg::RIM_MULT;
      dvs_pkg::SRC_SIN_BELL: scale_mult = dvs_pkg::BELL_MULT;
      default:               scale_mult = {1'b0, dvs_pkg::ENV_ONE};
    endcase
  end

  // Restoring divider step: one quotient bit per cycle. The numerator is
  // pre-shifted by 9, which gives the same floor as dividing by 512*T.
  assign div_den   = div_pitch ? dvs_pkg::kind_pitch_ms(kind_held)
                               : dvs_pkg::kind_amp_ms(kind_held);
  assign rem_sh    = {rem, dvd[20]};
  assign div_ge    = (rem_sh >= {1'b0, div_den});
  assign rem_sub   = 9'(rem_sh - {1'b0, div_den});
  assign quot      = {dvd[19:0], div_ge};
  assign num_amp   = {1'b0, prod[29:0]}
                     + {14'd0, dvs_pkg::kind_amp_ms(kind_held), 8'd0};
  assign num_pitch = {1'b0, spk} + {14'd0, dvs_pkg::kind_pitch_ms(kind_held), 8'd0};

  // LCG step from the two partial products; only the low 48 bits matter.
  assign lo_x5      = noise_seed[15:0] + {noise_seed[13:0], 2'b00};
  assign seed_hi    = seed_plo[47:32] + prod[15:0] + lo_x5;
  assign seed_new   = {seed_hi, seed_plo[31:0]} + dvs_pkg::LCG_ADD;
  assign noise_wave = {~seed_new[47], seed_new[46:32]};

  // Gain and final scaling with saturation.
  assign gain     = prod[40:23];
  assign mix_wide = prod[65:30];
  always_comb begin
    if (mix_wide > 36'sd32767) begin
      mix_sat = 16'h7FFF;
    end else if (mix_wide < -36'sd32768) begin
      mix_sat = 16'h8000;
    end else begin
      mix_sat = mix_wide[15:0];
    end
  end

  assign step_rnd   = prod[RND_W-1:0] + (RND_W'(1) << (PHASE_INT_BITS - 1));
  assign amp_diff   = {1'b0, amp_env} - {1'b0, amp_step};
  assign pitch_diff = {1'b0, pitch_env} - {1'b0, pitch_step};

  // Next state, multiplier operands and table address.
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    rom_addr   = phase_turns[FRAC_BITS-1 -: ROM_AW];
    unique case (state)
      dvs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == dvs_pkg::MODE_TRIGGER) begin
            if (kind_ok) state_next = dvs_pkg::ST_TRG_FREQ;
          end else if (sounding) begin
            state_next = dvs_pkg::ST_TERM;
          end else begin
            state_next = dvs_pkg::ST_DONE;
          end
        end
      end
      dvs_pkg::ST_TRG_FREQ: begin
        mul_a      = {21'd0, dvs_pkg::kind_freq(kind_held)};
        mul_b      = {13'd0, sample_period};
        state_next = dvs_pkg::ST_TRG_SCALE;
      end
      dvs_pkg::ST_TRG_SCALE: begin
        mul_a      = {13'd0, sample_period};
        mul_b      = dvs_pkg::MS_SCALE;
        state_next = dvs_pkg::ST_TRG_DIVLOAD;
      end
      dvs_pkg::ST_TRG_DIVLOAD: begin
        state_next = dvs_pkg::ST_TRG_DIV;
      end
      dvs_pkg::ST_TRG_DIV: begin
        if (div_cnt == dvs_pkg::DIV_LAST && (div_pitch || !pitched_held)) begin
          state_next = dvs_pkg::ST_IDLE;
        end
      end
      dvs_pkg::ST_TERM: begin
        unique case (term.src)
          dvs_pkg::SRC_NONE: begin
            mul_a      = {9'd0, amp_env};
            mul_b      = {17'd0, hit_level};
            state_next = dvs_pkg::ST_GAIN;
          end
          dvs_pkg::SRC_SIN_RAW: begin
            state_next = dvs_pkg::ST_WAVE_SIN;
          end
          dvs_pkg::SRC_SIN_KICK, dvs_pkg::SRC_SIN_TOM,
          dvs_pkg::SRC_SIN_RIM, dvs_pkg::SRC_SIN_BELL: begin
            mul_a      = {1'b0, phase_turns};
            mul_b      = {8'd0, scale_mult};
            state_next = dvs_pkg::ST_SCALE;
          end
          dvs_pkg::SRC_NOISE: begin
            mul_a      = {1'b0, noise_seed[31:0]};
            mul_b      = {1'b0, dvs_pkg::LCG_MULT_LO};
            state_next = dvs_pkg::ST_NOISE_LO;
          end
          default: begin
            state_next = dvs_pkg::ST_IDLE;
          end
        endcase
      end
      dvs_pkg::ST_SCALE: begin
        rom_addr   = prod[SCALE_TOP -: ROM_AW];
        state_next = dvs_pkg::ST_WAVE_SIN;
      end
      dvs_pkg::ST_WAVE_SIN: begin
        mul_a      = {17'd0, term.coef};
        mul_b      = {{17{sine_q[15]}}, sine_q};
        state_next = dvs_pkg::ST_ACC;
      end
      dvs_pkg::ST_NOISE_LO: begin
        mul_a      = {17'd0, noise_seed[47:32]};
        mul_b      = {17'd0, dvs_pkg::LCG_MULT_LO[15:0]};
        state_next = dvs_pkg::ST_NOISE_HI;
      end
      dvs_pkg::ST_NOISE_HI: begin
        mul_a      = {17'd0, term.coef};
        mul_b      = {{17{noise_wave[15]}}, noise_wave};
        state_next = dvs_pkg::ST_ACC;
      end
      dvs_pkg::ST_ACC: begin
        state_next = dvs_pkg::ST_TERM;
      end
      dvs_pkg::ST_GAIN: begin
        mul_a      = acc;
        mul_b      = {15'd0, gain};
        state_next = dvs_pkg::ST_MIX;
      end
      dvs_pkg::ST_MIX: begin
        state_next = dvs_pkg::ST_DONE;
      end
      dvs_pkg::ST_DONE: begin
        if (!out_valid || out_ch.ready) state_next = dvs_pkg::ST_IDLE;
      end
      default: begin
        state_next = dvs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dvs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier and sine table, both registered.
  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    sine_q <= SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= dvs_pkg::SAMPLE_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      sample_period <= cfg_wr_data;
    end
  end

  // Voice state and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      sounding    <= 1'b0;
      kind_held   <= dvs_pkg::KIND_KICK;
      hit_level   <= '0;
      phase_turns <= '0;
      phase_step  <= '0;
      amp_env     <= '0;
      amp_step    <= '0;
      pitch_env   <= '0;
      pitch_step  <= '0;
      noise_seed  <= 48'd1;
      term_idx    <= '0;
      div_cnt     <= '0;
      div_pitch   <= 1'b0;
    end else begin
      unique case (state)
        dvs_pkg::ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.mode == dvs_pkg::MODE_TRIGGER) begin
              if (kind_ok) begin
                sounding    <= 1'b1;
                kind_held   <= in_ch.drum_kind;
                hit_level   <= in_ch.velocity;
                phase_turns <= '0;
                amp_env     <= dvs_pkg::ENV_ONE;
                pitch_env   <= (dvs_pkg::kind_pitch_ms(in_ch.drum_kind) != 9'd0)
                               ? dvs_pkg::ENV_ONE : 24'd0;
                pitch_step  <= '0;
              end
            end else if (sounding) begin
              acc      <= '0;
              term_idx <= '0;
            end else begin
              mix_sample <= '0;
              mix_active <= 1'b0;
            end
          end
        end
        dvs_pkg::ST_TRG_SCALE: begin
          phase_step <= step_rnd[RND_W-1 -: 32];
        end
        dvs_pkg::ST_TRG_DIVLOAD: begin
          spk       <= prod[29:0];
          dvd       <= num_amp[29:9];
          rem       <= '0;
          div_cnt   <= '0;
          div_pitch <= 1'b0;
        end
        dvs_pkg::ST_TRG_DIV: begin
          if (div_cnt == dvs_pkg::DIV_LAST) begin
            if (div_pitch) begin
              pitch_step <= {3'd0, quot};
            end else begin
              amp_step <= {3'd0, quot};
              // Kick and toms also need the pitch decay step.
              if (pitched_held) begin
                dvd       <= num_pitch[29:9];
                rem       <= '0;
                div_cnt   <= '0;
                div_pitch <= 1'b1;
              end
            end
          end else begin
            dvd     <= quot;
            rem     <= div_ge ? rem_sub : rem_sh[8:0];
            div_cnt <= div_cnt + 5'd1;
          end
        end
        dvs_pkg::ST_NOISE_LO: begin
          seed_plo <= prod[47:0];
        end
        dvs_pkg::ST_NOISE_HI: begin
          noise_seed <= seed_new;
        end
        dvs_pkg::ST_ACC: begin
          acc      <= acc + prod[32:0];
          term_idx <= term_idx + 2'd1;
        end
        dvs_pkg::ST_MIX: begin
          mix_sample  <= mix_sat;
          phase_turns <= phase_turns + phase_step;
          if (pitched_held) begin
            pitch_env <= pitch_diff[24] ? 24'd0 : pitch_diff[23:0];
          end
          if (amp_diff[24] || amp_diff == 25'd0) begin
            amp_env    <= '0;
            sounding   <= 1'b0;
            mix_active <= 1'b0;
          end else begin
            amp_env    <= amp_diff[23:0];
            mix_active <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: holds the finished sample while the next beat comes in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready) out_valid <= 1'b0;
      if (state == dvs_pkg::ST_DONE && (!out_valid || out_ch.ready)) begin
        out_valid  <= 1'b1;
        out_sample <= mix_sample;
        out_active <= mix_active;
      end
    end
  end

  // A silent voice always has its amplitude envelope at rest.
  `DVS_ASSERT_IMPL(a_silent_env_zero, !sounding, amp_env == 24'd0)
  // Envelopes only decay from full scale.
  `DVS_ASSERT_IMPL(a_env_bound, 1'b1, (amp_env <= dvs_pkg::ENV_ONE) && (pitch_env <= dvs_pkg::ENV_ONE))
  // A tick on a silent voice goes straight to the output stage.
  `DVS_ASSERT_NEXT(a_silent_tick, in_fire && (in_ch.mode == dvs_pkg::MODE_TICK) && !sounding, state == dvs_pkg::ST_DONE)
  // New samples only appear from the final sequencer state.
  `DVS_ASSERT_IMPL(a_out_from_done, $rose(out_valid), $past(state) == dvs_pkg::ST_DONE)
  // The divider never runs past its last quotient bit.
  `DVS_ASSERT_IMPL(a_div_count, state == dvs_pkg::ST_TRG_DIV, div_cnt <= dvs_pkg::DIV_LAST)

endmodule

### bench/drum_voice_synth_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Drum voice synthesizer testbench
// Drives trigger and tick beats into the voice under random idling and a
// long output hold-off. A scoreboard predicts every sample and compares it.
// The sample period is changed between phases, including its extremes.
// ---------------------------------------------------------------------------
import dvs_pkg::*;

class voice_scoreboard;
  typedef struct {
    logic signed [15:0] sample;
    logic               active;
  } voice_out_t;

  voice_out_t        sample_fifo[$];
  int                errors;
  logic [19:0]       period;
  bit                sounding;
  logic [3:0]        kind;
  logic [15:0]       level;
  logic [31:0]       phase;
  logic [31:0]       phase_inc;
  int                amp;
  logic [23:0]       amp_dec;
  int                pitch;
  logic [23:0]       pitch_dec;
  logic [47:0]       seed;

  function new();
    errors = 0;
    period = SAMPLE_PERIOD_RESET;
    sounding = 0;
    kind = 0;
    level = 0;
    phase = 0;
    phase_inc = 0;
    amp = 0;
    amp_dec = 0;
    pitch = 0;
    pitch_dec = 0;
    seed = 48'd1;
  endfunction

  function int pending();
    return sample_fifo.size();
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function longint quarter_wave(longint r);
    longint z, z2, a, y;
    z  = r << 16;
    z2 = (z * z) >>> 30;
    a  = 172270;
    a  = ((a * z2) >>> 30) - 5026995;
    a  = ((a * z2) >>> 30) + 85569305;
    a  = ((a * z2) >>> 30) - 693598668;
    a  = ((a * z2) >>> 30) + 1686629713;
    y  = (((a * z) >>> 30) + 16384) >>> 15;
    if (y > 32767) y = 32767;
    return y;
  endfunction

  function longint sine_of(logic [31:0] arg);
    longint k, p, q, r, v;
    k = (longint'(arg[23:0]) * 1024) >> 24;
    p = ((k << 16) / 1024) & 16'hFFFF;
    q = p >> 14;
    r = p & 16'h3FFF;
    if (q[0]) r = 16384 - r;
    v = quarter_wave(r);
    return (q >= 2) ? -v : v;
  endfunction

  function logic [31:0] scaled(logic [31:0] mult);
    logic [63:0] prod;
    prod = {32'd0, phase} * {32'd0, mult};
    return prod[54:23];
  endfunction

  function longint noise();
    logic [63:0] nxt;
    nxt = {16'd0, seed} * 64'h5DEECE66D + 64'd11;
    seed = nxt[47:0];
    return longint'(seed[47:32]) - 32768;
  endfunction

  function logic [23:0] decay_step(int ms);
    logic [63:0] q;
    q = (64'(period) * 1000 + 256 * ms) / (512 * ms);
    return q[23:0];
  endfunction

  function void trigger(logic [15:0] vel, logic [3:0] k);
    int f, amp_ms, pitch_ms;
    logic [63:0] inc;
    pitch_ms = 0;
    case (k)
      KIND_KICK:    begin f = 60;   amp_ms = 300; pitch_ms = 50; end
      KIND_SNARE:   begin f = 400;  amp_ms = 200; end
      KIND_HAT:     begin f = 0;    amp_ms = 50;  end
      KIND_TOM_LO:  begin f = 80;   amp_ms = 400; pitch_ms = 80; end
      KIND_TOM_MID: begin f = 120;  amp_ms = 350; pitch_ms = 70; end
      KIND_TOM_HI:  begin f = 180;  amp_ms = 300; pitch_ms = 60; end
      KIND_CLAP:    begin f = 0;    amp_ms = 150; end
      KIND_RIM:     begin f = 800;  amp_ms = 30;  end
      KIND_COWBELL: begin f = 540;  amp_ms = 200; end
      KIND_CLAVE:   begin f = 2500; amp_ms = 20;  end
      KIND_PERC:    begin f = 0;    amp_ms = 100; end
      default:      return;  // unknown kinds leave the voice untouched
    endcase
    sounding = 1;
    kind = k;
    level = vel;
    phase = 0;
    inc = (64'(f) * period + 128) >> 8;
    phase_inc = inc[31:0];
    amp = ENV_ONE;
    amp_dec = decay_step(amp_ms);
    if (pitch_ms != 0) begin
      pitch = ENV_ONE;
      pitch_dec = decay_step(pitch_ms);
    end else begin
      pitch = 0;
      pitch_dec = 0;
    end
  endfunction

  function void tick();
    voice_out_t e;
    longint total, s, g;
    bit pitched;
    if (!sounding) begin
      e.sample = 0;
      e.active = 0;
      sample_fifo.push_back(e);
      return;
    end
    pitched = 0;
    case (kind)
      KIND_KICK: begin
        total = 32768 * sine_of(scaled(32'(ENV_ONE) + 2 * pitch));
        pitched = 1;
      end
      KIND_SNARE: begin
        total = 22938 * noise();
        total += 6881 * sine_of(phase);
      end
      KIND_TOM_LO, KIND_TOM_MID, KIND_TOM_HI: begin
        total = 26214 * sine_of(scaled(32'(ENV_ONE) + pitch + (pitch >> 1)));
        total += 3277 * noise();
        pitched = 1;
      end
      KIND_CLAP: total = 19661 * noise();
      KIND_RIM: begin
        total = 16384 * sine_of(phase);
        total += 9830 * sine_of(scaled(32'(RIM_MULT)));
        total += 6554 * noise();
      end
      KIND_COWBELL: begin
        total = 9175 * sine_of(phase);
        total += 6881 * sine_of(scaled(32'(BELL_MULT)));
      end
      KIND_CLAVE: total = 19661 * sine_of(phase);
      default: total = 16384 * noise();
    endcase
    g = (longint'(amp) * level) >> 23;
    s = (total * g) >>> 30;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    phase = phase + phase_inc;
    amp = amp - int'(amp_dec);
    if (pitched) begin
      pitch = pitch - int'(pitch_dec);
      if (pitch < 0) pitch = 0;
    end
    if (amp <= 0) begin
      amp = 0;
      sounding = 0;
    end
    e.sample = s[15:0];
    e.active = sounding;
    sample_fifo.push_back(e);
  endfunction

  function void note_beat(logic mode, logic [15:0] vel, logic [3:0] k);
    if (mode == MODE_TRIGGER) trigger(vel, k);
    else tick();
  endfunction

  task check_sample(logic signed [15:0] sample, logic active);
    voice_out_t e;
    if (sample_fifo.size() == 0) begin
      report($sformatf("unexpected sample %0d", sample));
      return;
    end
    e = sample_fifo.pop_front();
    if (sample !== e.sample)
      report($sformatf("sample got %0d want %0d", sample, e.sample));
    if (active !== e.active)
      report($sformatf("voice_active got %0b want %0b", active, e.active));
  endtask
endclass

module drum_voice_synth_tb;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [19:0] cfg_wr_data;

  dvs_in_if  in_ch ();
  dvs_out_if out_ch ();

  drum_voice_synth uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  voice_scoreboard sb = new();

  // Idling percentages of the current phase, and the hold-off request count.
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet = 0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_TICK;
    in_ch.velocity = '0;
    in_ch.drum_kind = '0;
    out_ch.ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random; on request it holds off for a long
  // stretch, so the finished sample blocks the sequencer and in_ch backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_served) begin
      hold_served = hold_req;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Sample beats are checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_sample(out_ch.sample, out_ch.voice_active);
  end

  // Watchdog: a long run of cycles with no beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one command beat, after an optional random gap, and predicts it
  // at the edge where it is taken.
  task send_beat(logic mode, logic [15:0] vel, logic [3:0] k);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.velocity <= vel;
    in_ch.drum_kind <= k;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(mode, vel, k);
  endtask

  task send_tick();
    send_beat(MODE_TICK, 16'($urandom), 4'($urandom));
  endtask

  // The period register changes only once the voice has drained; the pause
  // covers a trigger still in its divider, which returns no sample.
  task write_period(logic [19:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.period = value;
  endtask

  task directed_hits();
    send_tick();  // idle voice gives silence
    send_beat(MODE_TRIGGER, 16'd32768, KIND_KICK);
    send_tick();
    send_tick();
    send_beat(MODE_TRIGGER, 16'hFFFF, KIND_SNARE);
    send_tick();
    send_beat(MODE_TRIGGER, 16'd0, KIND_HAT);
    send_tick();
    send_beat(MODE_TRIGGER, 16'hFFFF, 4'd15);  // unknown kind is ignored
    send_tick();
    for (int k = KIND_TOM_LO; k <= KIND_PERC; k++) begin
      send_beat(MODE_TRIGGER, 16'($urandom_range(16384, 40000)), 4'(k));
      send_tick();
    end
  endtask

  // Mostly whole hits: a trigger followed by a run of ticks, sometimes long
  // enough for the voice to die out. The rest is loose beats and unknown-kind triggers.
  task random_hits(int budget);
    int count, r, n;
    logic [15:0] vel;
    count = 0;
    while (count < budget) begin
      r = $urandom_range(0, 9);
      vel = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
      if (r < 7) begin
        send_beat(MODE_TRIGGER, vel, 4'($urandom_range(0, 10)));
        n = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        repeat (n) send_tick();
        count += n + 1;
      end else if (r == 7) begin
        send_beat(MODE_TRIGGER, vel, 4'($urandom_range(11, 15)));
      end else begin
        send_beat(1'($urandom), vel, 4'($urandom));
        count++;
      end
    end
  endtask

  logic [19:0] periods[6] = '{20'd536871, 20'd22369, 20'd0, 20'hFFFFF, 20'd89478, 20'd0};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_hits();
    periods[5] = 20'($urandom_range(22369, 536871));
    for (int ph = 0; ph < 6; ph++) begin
      write_period(periods[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      if (ph == 0) hold_req++;
      random_hits(220);
    end
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl/core
rtl/core/dvs_pkg.sv
rtl/core/dvs_ifs.sv
rtl/core/drum_voice_synth.sv
bench/drum_voice_synth_tb.sv
